/* rtl/core/slrg_pkg.sv */
// Package with types, constants and index helpers for the subtractive random generator.
`default_nettype none

package slrg_pkg;

    // Word and index widths.
    localparam int unsigned WordW = 30;
    localparam int unsigned PosW  = 6;
    localparam int unsigned SeedW = 28;

    // Generator constants.
    localparam logic [WordW-1:0] Modulus     = 30'd1000000000;
    localparam logic [SeedW-1:0] SeedBase    = 28'd161803398;
    localparam int unsigned      TableLen    = 55;
    localparam logic [PosW-1:0]  LastPos     = 6'd55;
    localparam logic [PosW-1:0]  ScatterStep = 6'd21;
    localparam logic [PosW-1:0]  LagStart    = 6'd31;
    localparam logic [PosW-1:0]  MixOther    = 6'd32;

    // Configuration register indexes.
    localparam logic RegSeed = 1'b0;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FILL   = 6'b000010,
        ST_MIX_RD = 6'b000100,
        ST_MIX_WR = 6'b001000,
        ST_GEN_RD = 6'b010000,
        ST_GEN_WR = 6'b100000
    } t_state;

    // Advance a table position by one, wrapping from 55 back to 1.
    function automatic logic [PosW-1:0] pos_next(input logic [PosW-1:0] pos);
        logic [PosW-1:0] res;
        res = (pos >= LastPos) ? 6'd1 : pos + 6'd1;
        return res;
    endfunction

    // Advance a position by the scatter step, modulo 55.
    function automatic logic [PosW-1:0] pos_scatter(input logic [PosW-1:0] pos);
        logic [PosW:0] sum;
        logic [PosW:0] res;
        sum = {1'b0, pos} + {1'b0, ScatterStep};
        res = (sum >= {1'b0, LastPos}) ? sum - {1'b0, LastPos} : sum;
        return res[PosW-1:0];
    endfunction

    // Memory address of a table position.
    function automatic logic [PosW-1:0] pos_addr(input logic [PosW-1:0] pos);
        logic [PosW-1:0] res;
        res = pos - 6'd1;
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/slrg_submod.sv */
// Shared modular subtract unit: (a - b) mod 10^9 for operands below 10^9.
`default_nettype none

module slrg_submod
    import slrg_pkg::*;
(
    input  wire logic [WordW-1:0] i_a,
    input  wire logic [WordW-1:0] i_b,
    output logic      [WordW-1:0] o_diff
);

    logic [WordW:0] diff;

    // One wide subtract; on borrow the modulus is added back.
    always_comb begin
        diff = {1'b0, i_a} - {1'b0, i_b};
        if (diff[WordW]) begin
            o_diff = diff[WordW-1:0] + Modulus;
        end else begin
            o_diff = diff[WordW-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/slrg_table.sv */
// Lag table memory: one write port and two registered read ports.
`default_nettype none

module slrg_table
    import slrg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [PosW-1:0]  i_waddr,
    input  wire logic [WordW-1:0] i_wdata,
    input  wire logic [PosW-1:0]  i_raddr_a,
    input  wire logic [PosW-1:0]  i_raddr_b,
    output logic      [WordW-1:0] o_rdata_a,
    output logic      [WordW-1:0] o_rdata_b
);

    logic [WordW-1:0] r_mem [TableLen];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

/* rtl/core/subtractive_lagged_random_generator_top.sv */
// An accepted beat, when the table is ready, passes a read state and then a write-back state
// through the shared subtract unit and the table ports; write-back waits for a free output register.
// A new beat is accepted only in idle, so only after the previous result has been written back.
// A beat that rebuilds the table first fills all 55 positions, then mixes them in four passes.
// Reset (synchronous, active low) clears the seed, the indices and the initialized flag; the
// first beat after reset always rebuilds the table.
`default_nettype none

module subtractive_lagged_random_generator_top
    import slrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [0] reseed, [7:1] zero
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [29:0] value, [31:30] zero
    // Configuration port.
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    t_state           r_state, n_state;
    logic [SeedW-1:0] r_seed;
    logic             r_init, n_init;
    logic [PosW-1:0]  r_idx_a, n_idx_a;
    logic [PosW-1:0]  r_idx_b, n_idx_b;
    logic [PosW-1:0]  r_cnt, n_cnt;
    logic [1:0]       r_pass, n_pass;
    logic [WordW-1:0] r_prev, n_prev;
    logic [WordW-1:0] r_cur, n_cur;
    logic             r_out_valid, n_out_valid;
    logic [WordW-1:0] r_out_data, n_out_data;

    logic             in_beat;
    logic             cfg_write;
    logic [SeedW-1:0] seed_sat;
    logic [WordW-1:0] sub_a, sub_b, sub_q;
    logic             mem_we;
    logic [PosW-1:0]  mem_waddr;
    logic [WordW-1:0] mem_wdata;
    logic [PosW-1:0]  rd_pos_a, rd_pos_b;
    logic [WordW-1:0] rd_a, rd_b;

    // Configuration port: always ready, seed at index zero.
    assign o_pready  = 1'b1;
    assign cfg_write = i_psel & i_penable & i_pwrite & o_pready;
    assign o_prdata  = (i_paddr[2] == RegSeed) ? {{(32-SeedW){1'b0}}, r_seed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (cfg_write && (i_paddr[2] == RegSeed)) begin
            r_seed <= i_pwdata[SeedW-1:0];
        end
    end

    // Seed saturates so the first table value is never negative.
    assign seed_sat = (r_seed > SeedBase) ? SeedBase : r_seed;

    // Handshake.
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_beat    = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_data};

    // Shared subtract unit: fill recurrence or table operands.
    always_comb begin
        if (r_state == ST_FILL) begin
            sub_a = r_prev;
            sub_b = r_cur;
        end else begin
            sub_a = rd_a;
            sub_b = rd_b;
        end
    end

    slrg_submod u_submod (
        .i_a    (sub_a),
        .i_b    (sub_b),
        .o_diff (sub_q)
    );

    // Read addresses: the generate step reads at the advanced indices.
    always_comb begin
        if (r_state == ST_GEN_RD) begin
            rd_pos_a = pos_next(r_idx_a);
            rd_pos_b = pos_next(r_idx_b);
        end else begin
            rd_pos_a = r_idx_a;
            rd_pos_b = r_idx_b;
        end
    end

    slrg_table u_table (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (pos_addr(rd_pos_a)),
        .i_raddr_b (pos_addr(rd_pos_b)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = pos_addr(r_idx_a);
        mem_wdata   = sub_q;

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_s_tdata[0] || !r_init) begin
                        n_state = ST_FILL;
                        n_prev  = WordW'(SeedBase) - WordW'(seed_sat);
                        n_cur   = 30'd1;
                        n_idx_a = ScatterStep;
                        n_cnt   = '0;
                    end else begin
                        n_state = ST_GEN_RD;
                    end
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (r_cnt == '0) begin
                    // The top position takes the seed-derived value.
                    mem_waddr = pos_addr(LastPos);
                    mem_wdata = r_prev;
                end else begin
                    // Scattered fill; the value written becomes the next previous one.
                    mem_waddr = pos_addr(r_idx_a);
                    mem_wdata = r_cur;
                    n_cur     = sub_q;
                    n_prev    = r_cur;
                    n_idx_a   = pos_scatter(r_idx_a);
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == LastPos - 6'd1) begin
                    n_state = ST_MIX_RD;
                    n_idx_a = 6'd1;
                    n_idx_b = MixOther;
                    n_cnt   = '0;
                    n_pass  = '0;
                end
            end
            ST_MIX_RD: begin
                n_state = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                mem_we    = 1'b1;
                mem_waddr = pos_addr(r_idx_a);
                n_idx_a   = pos_next(r_idx_a);
                n_idx_b   = pos_next(r_idx_b);
                n_cnt     = r_cnt + 6'd1;
                n_state   = ST_MIX_RD;
                if (r_cnt == LastPos - 6'd1) begin
                    n_cnt  = '0;
                    n_pass = r_pass + 2'd1;
                    if (r_pass == 2'd3) begin
                        // Table ready: indices restart and the value follows.
                        n_init  = 1'b1;
                        n_idx_a = '0;
                        n_idx_b = LagStart;
                        n_state = ST_GEN_RD;
                    end
                end
            end
            ST_GEN_RD: begin
                n_idx_a = pos_next(r_idx_a);
                n_idx_b = pos_next(r_idx_b);
                n_state = ST_GEN_WR;
            end
            ST_GEN_WR: begin
                // Write back and present the value once the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    mem_we      = 1'b1;
                    mem_waddr   = pos_addr(r_idx_a);
                    n_out_valid = 1'b1;
                    n_out_data  = sub_q;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= 1'b0;
            r_idx_a     <= '0;
            r_idx_b     <= LagStart;
            r_cnt       <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_idx_a     <= n_idx_a;
            r_idx_b     <= n_idx_b;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

/* tb/slrg_checker.sv */
// Stream and register monitor that predicts each generated value and compares it.
`timescale 1ns / 1ps

module slrg_checker
    import slrg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,    // [0] reseed, [7:1] zero
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,    // [29:0] value, [31:30] zero
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int unsigned      o_mismatches,
    output int unsigned      o_pending
);

    // Offset for a table position's mixing partner during warm-up; the partner lies 31 positions on.
    localparam int MixLag = 30;

    // Local copy of the generator state, positions numbered 1..55.
    logic [WordW-1:0] lag_ring [1:TableLen];
    logic [PosW-1:0]  lead_pos;
    logic [PosW-1:0]  trail_pos;
    logic             ring_ready;
    logic [SeedW-1:0] seed_word;

    // Values owed by the block, oldest first.
    logic [WordW-1:0] owed_values [$];
    int unsigned      mismatch_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = owed_values.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Difference modulo one billion of two words that are already below it.
    function automatic logic [WordW-1:0] mod_diff(input logic [WordW-1:0] a,
                                                   input logic [WordW-1:0] b);
        return (a >= b) ? a - b : a + Modulus - b;
    endfunction

    // Scattered fill from the clamped seed, then four warm-up passes.
    function automatic void rebuild_ring();
        logic [SeedW-1:0] clamped;
        logic [WordW-1:0] prev;
        logic [WordW-1:0] cur;
        int pos;
        int partner;
        clamped = (seed_word > SeedBase) ? SeedBase : seed_word;
        prev = {2'b00, SeedBase - clamped};
        cur = 1;
        lag_ring[TableLen] = prev;
        for (int i = 1; i < TableLen; i++) begin
            pos = (int'(ScatterStep) * i) % TableLen;
            lag_ring[pos] = cur;
            cur = mod_diff(prev, cur);
            prev = lag_ring[pos];
        end
        for (int pass = 0; pass < 4; pass++) begin
            for (int i = 1; i <= TableLen; i++) begin
                partner = 1 + (i + MixLag) % TableLen;
                lag_ring[i] = mod_diff(lag_ring[i], lag_ring[partner]);
            end
        end
        lead_pos = '0;
        trail_pos = LagStart;
        ring_ready = 1'b1;
    endfunction

    // Produce the next value, rebuilding the table first when asked or not yet built.
    function automatic logic [WordW-1:0] draw_value(input logic reseed);
        logic [WordW-1:0] v;
        if (reseed || !ring_ready) begin
            rebuild_ring();
        end
        lead_pos = (lead_pos >= LastPos) ? 6'd1 : lead_pos + 6'd1;
        trail_pos = (trail_pos >= LastPos) ? 6'd1 : trail_pos + 6'd1;
        v = mod_diff(lag_ring[lead_pos], lag_ring[trail_pos]);
        lag_ring[lead_pos] = v;
        return v;
    endfunction

    always @(posedge i_clk) begin
        logic [WordW-1:0] want;
        if (!i_rst_n) begin
            owed_values.delete();
            seed_word = '0;
            lead_pos = '0;
            trail_pos = LagStart;
            ring_ready = 1'b0;
        end else begin
            // Register traffic: track writes, check read-back of the seed.
            if (i_psel && i_penable && i_pready && i_paddr[2] == RegSeed) begin
                if (i_pwrite) begin
                    seed_word = i_pwdata[SeedW-1:0];
                end else if (i_prdata !== {4'b0000, seed_word}) begin
                    report_mismatch("seed read-back", i_prdata, {4'b0000, seed_word});
                end
            end

            // Each accepted request owes exactly one value.
            if (i_s_tvalid && i_s_tready) begin
                owed_values.push_back(draw_value(i_s_tdata[0]));
            end

            // Compare each delivered beat with the oldest owed value.
            if (i_m_tvalid && i_m_tready) begin
                if (owed_values.size() == 0) begin
                    report_mismatch("result with no request pending", i_m_tdata, 0);
                end else begin
                    want = owed_values.pop_front();
                    if (i_m_tdata[WordW-1:0] !== want) begin
                        report_mismatch("value", i_m_tdata[WordW-1:0], want);
                    end
                    if (i_m_tdata[31:WordW] !== 2'b00) begin
                        report_mismatch("padding bits", i_m_tdata[31:WordW], 0);
                    end
                end
            end
        end
    end

endmodule

/* tb/testbench.sv */
// Top-level testbench: clock, reset, request and register stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
    import slrg_pkg::*;

    localparam int unsigned QuietLimit  = 5000;
    localparam int          PhaseItems  = 220;
    localparam logic [2:0]  SeedAddr    = {RegSeed, 2'b00};
    localparam logic [2:0]  SpareAddr   = {~RegSeed, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned requests = 0;
    int unsigned reseeds = 0;
    int unsigned seed_writes = 0;

    subtractive_lagged_random_generator_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    slrg_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Clock with a 2 ns period.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure at the rate of the current phase.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: too long without any beat or register access ends the run.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("FAIL subtractive_lagged_random_generator_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One request beat, after a random idle gap that may be empty; tvalid stays high for back-to-back beats.
    task automatic send_request(input logic reseed);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, reseed};
        do @(posedge clk); while (!s_tready);
        requests++;
        if (reseed) reseeds++;
    endtask

    // One register access: setup phase, then access until pready.
    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (wr) seed_writes++;
    endtask

    // Stop sending and let every owed value drain before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the seed, read it back, and start with a reseed so the new seed takes effect.
    task automatic reseed_with(input logic [31:0] word, input int extra);
        drain();
        reg_access(1'b1, SeedAddr, word);
        reg_access(1'b0, SeedAddr, '0);
        send_request(1'b1);
        repeat (extra) send_request(1'b0);
    endtask

    initial begin
        int reseed_pct;
        logic [31:0] word;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first request builds the table from the reset seed of zero.
        send_request(1'b0);
        repeat (3) send_request(1'b0);
        // Reseed while already initialized.
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        // Largest legal seed makes the first table value zero.
        reseed_with(32'(SeedBase), 2);
        // All ones: seed masks to 28 bits and then saturates.
        reseed_with(32'hFFFF_FFFF, 1);
        // Just above range, followed by a write to an unused register that must be ignored.
        drain();
        reg_access(1'b1, SeedAddr, 32'(SeedBase) + 1);
        reg_access(1'b1, SpareAddr, 32'h0000_1234);
        reg_access(1'b0, SeedAddr, '0);
        send_request(1'b1);
        send_request(1'b0);
        // Zero seed again with a short run.
        reseed_with(32'h0, 2);

        // Random phases with different idling, stalling, reseed rates and seeds.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;  stall_pct = 0;  reseed_pct = 2;
                    word = $urandom_range(SeedBase);
                end
                1: begin
                    idle_pct = 63; stall_pct = 0;  reseed_pct = 1;
                    word = $urandom_range(SeedBase);
                end
                2: begin
                    idle_pct = 0;  stall_pct = 63; reseed_pct = 5;
                    word = 32'(SeedBase);
                end
                default: begin
                    idle_pct = 29; stall_pct = 29; reseed_pct = 3;
                    word = $urandom;
                end
            endcase
            reseed_with(word, 0);
            for (int n = 1; n < PhaseItems; n++) begin
                send_request($urandom_range(99) < reseed_pct);
            end
        end

        // Let the last values arrive, then a short settling pause.
        stall_pct = 0;
        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d requests, %0d of them reseeding, and %0d register writes,",
                 requests, reseeds, seed_writes);
        $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
        if (mismatches == 0) begin
            $display("PASS subtractive_lagged_random_generator_top");
        end else begin
            $display("FAIL subtractive_lagged_random_generator_top");
        end
        $finish;
    end

endmodule

/* subtractive_lagged_random_generator_top.f */
rtl/core/slrg_pkg.sv
rtl/core/slrg_submod.sv
rtl/core/slrg_table.sv
rtl/core/subtractive_lagged_random_generator_top.sv
tb/slrg_checker.sv
tb/testbench.sv
